// ----- rtl/pba_pkg.sv -----
// Package for the page block allocator: field widths, status codes,
// configuration register indexes and reset values.
// No dependencies.
package pba_pkg;

  localparam int TABLE_SIZE_DEFAULT = 256;

  localparam int ADDR_W     = 32;
  localparam int PAGE_NUM_W = 20;
  localparam int PAGES_W    = 21;
  localparam int OFFSET_W   = 12;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [PAGE_NUM_W-1:0] HEAP_START_RESET = 20'd786434;
  localparam logic [PAGES_W-1:0]    HEAP_LIMIT_RESET = 21'd1048576;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

endpackage

// ----- rtl/page_block_allocator.sv -----
// First-fit page allocator over a block table held in one synchronous memory.
// Depends on pba_pkg.
//
//   channel   valid / ready          payload
//   in        in_valid / in_ready    req_type, size_bytes, free_address
//   out       out_valid / out_ready  block_address, status
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item scans the table in order for the first entry that fits or matches, and
// an allocate that adds an entry then passes the append state before the response
// state. The scan reads one entry per cycle from the single memory read port.
// A zero-size allocate skips the scan. Reset is synchronous and empties the
// table at once through the entry count. A new item is taken while a result
// still waits on the output; an item finishing behind a stalled result waits.
// Configuration writes are always taken.
module page_block_allocator #(
  parameter int TABLE_SIZE = pba_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [pba_pkg::ADDR_W-1:0]      size_bytes,
  input  logic [pba_pkg::ADDR_W-1:0]      free_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pba_pkg::ADDR_W-1:0]      block_address,
  output logic [pba_pkg::STATUS_W-1:0]    status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pba_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int MEM_W = 1 + PAGES_W + PAGE_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPEND = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state;

  logic [MEM_W-1:0] mem [TABLE_SIZE];
  logic [MEM_W-1:0] rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  logic [PAGE_NUM_W-1:0] heap_start;
  logic [PAGES_W-1:0]    heap_limit;
  logic [PAGES_W-1:0]    heap_used;
  logic [CNT_W-1:0]      entry_count;

  logic                  req_free;
  logic [PAGES_W-1:0]    need;
  logic [ADDR_W-1:0]     addr_q;
  logic [CNT_W-1:0]      rd_idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_ix;
  logic [PAGE_NUM_W-1:0] app_page;
  logic [ADDR_W-1:0]     res_addr;
  logic [STATUS_W-1:0]   res_status;

  logic                  rd_res;
  logic [PAGES_W-1:0]    rd_pages;
  logic [PAGE_NUM_W-1:0] rd_pn;
  logic                  fit;
  logic                  exact;
  logic                  addr_hit;
  logic                  hit;
  logic                  scan_end;
  logic                  table_full;
  logic                  issue;
  logic [PAGES_W-1:0]    shrink;
  logic [PAGE_NUM_W-1:0] top;
  logic [PAGES_W:0]      heap_sum;
  logic                  exhausted;
  logic [PAGE_NUM_W-1:0] heap_end_page;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rd_res        = rd_data[MEM_W-1];
    rd_pages      = rd_data[MEM_W-2 -: PAGES_W];
    rd_pn         = rd_data[PAGE_NUM_W-1:0];
    fit           = !rd_res && (rd_pages >= need);
    exact         = (rd_pages == need);
    addr_hit      = ({rd_pn, {OFFSET_W{1'b0}}} == addr_q);
    hit           = (state == S_SCAN) && rd_vld && (req_free ? addr_hit : fit);
    scan_end      = (rd_idx >= entry_count) && !rd_vld;
    table_full    = (entry_count >= CNT_W'(TABLE_SIZE));
    issue         = (state == S_SCAN) && !hit && (rd_idx < entry_count);
    shrink        = rd_pages - need;
    top           = rd_pn + shrink[PAGE_NUM_W-1:0];
    heap_sum      = {1'b0, heap_used} + {1'b0, need};
    exhausted     = (heap_sum > {1'b0, heap_limit});
    heap_end_page = heap_start + heap_used[PAGE_NUM_W-1:0];

    mem_we    = 1'b0;
    mem_waddr = rd_ix;
    mem_wdata = {1'b0, rd_pages, rd_pn};
    if (hit) begin
      if (req_free) begin
        mem_we = rd_res;
      end else if (exact) begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, rd_pages, rd_pn};
      end else begin
        mem_we    = !table_full;
        mem_wdata = {1'b0, shrink, rd_pn};
      end
    end else if (state == S_APPEND) begin
      mem_we    = 1'b1;
      mem_waddr = entry_count[IDX_W-1:0];
      mem_wdata = {1'b1, need, app_page};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      entry_count <= '0;
      heap_used   <= '0;
      heap_start  <= HEAP_START_RESET;
      heap_limit  <= HEAP_LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEAP_START: heap_start <= cfg_data[PAGE_NUM_W-1:0];
          CFG_HEAP_LIMIT: heap_limit <= cfg_data[PAGES_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_free <= req_type;
            need     <= {1'b0, size_bytes[ADDR_W-1:OFFSET_W]}
                        + PAGES_W'(|size_bytes[OFFSET_W-1:0]);
            addr_q   <= free_address;
            rd_idx   <= '0;
            rd_vld   <= 1'b0;
            res_addr <= '0;
            if (req_type == REQ_ALLOC && size_bytes == '0) begin
              res_status <= ST_ZERO;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld <= issue;
          rd_ix  <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (hit) begin
            if (req_free) begin
              res_status <= rd_res ? ST_OK : ST_DOUBLE;
              state      <= S_RESP;
            end else if (exact) begin
              res_status <= ST_OK;
              res_addr   <= {rd_pn, {OFFSET_W{1'b0}}};
              state      <= S_RESP;
            end else if (table_full) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              app_page   <= top;
              res_addr   <= {top, {OFFSET_W{1'b0}}};
              res_status <= ST_OK;
              state      <= S_APPEND;
            end
          end else if (scan_end) begin
            if (req_free) begin
              res_status <= ST_UNKNOWN;
              state      <= S_RESP;
            end else if (table_full) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else if (exhausted) begin
              res_status <= ST_EXHAUSTED;
              state      <= S_RESP;
            end else begin
              app_page   <= heap_end_page;
              res_addr   <= {heap_end_page, {OFFSET_W{1'b0}}};
              res_status <= ST_OK;
              heap_used  <= heap_sum[PAGES_W-1:0];
              state      <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          entry_count <= entry_count + 1'b1;
          state       <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            block_address <= res_addr;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_SIZE))
    else $error("entry count beyond table size");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, mem_waddr} <= {1'b0, entry_count}) &&
               ((state == S_APPEND) || ({1'b0, mem_waddr} < {1'b0, entry_count})))
    else $error("table write outside the filled entries");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (block_address == '0))
    else $error("failed item carries an address");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> !table_full)
    else $error("append with a full table");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == S_SCAN))
    else $error("read data valid outside a scan");
`endif

endmodule
